[rtl/spq_pkg.sv]
// ============================================================================
// spq_pkg
// Shared types and constants for the stable priority queue: status codes,
// command codes, controller states and the controller-to-datapath command.
// ============================================================================
package spq_pkg;

    // Default number of entries the queue can hold.
    localparam int CAPACITY_DEF = 16;

    // Field widths of the item and result channels.
    localparam int HANDLE_W  = 32;
    localparam int TYPE_W    = 16;
    localparam int PRIO_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int OUT_CNT_W = 5;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_NULL  = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming item
        logic compare;  // evaluate the per-cell match and position flags
        logic commit;   // apply the operation and load the result register
    } ctrl_cmd_t;

endpackage

[rtl/stable_priority_queue_unit.sv]
// ============================================================================
// stable_priority_queue_unit
// Bounded priority queue of up to CAPACITY entries kept in ascending priority
// order, with first-in, first-out order among equal priorities.
// ============================================================================
//
// Usage:
// The input channel (s_*) carries one command per transfer: an insert of a
// handle, type and signed priority, or a removal of the lowest-priority entry.
// The result channel (m_*) returns exactly one result per command: a status
// code, the removed entry (zero unless a removal succeeds) and the count held
// after the operation.
// Each item passes through the accept cycle, a compare cycle in which every
// storage cell compares its entry against the item in parallel, and an
// update cycle in which the row of cells shifts and the result register
// loads. The result is valid the cycle after the update, and a new command
// is accepted then as well; no new command is accepted while an item is in
// compare or update. The per-cell compare and the single-step shift of the
// cell row keep this sequence independent of CAPACITY.
// A result waiting in the output register does not block the next accept;
// if the receiver still stalls when the next update is due, the update waits
// until the pending result is transferred.
// Reset clears the held count and the control state; the cell contents are
// not cleared, since only entries below the count are ever read.
//
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [HANDLE_W-1:0]      s_item_handle,
    input  logic [TYPE_W-1:0]        s_item_type,
    input  logic signed [PRIO_W-1:0] s_priority_req,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [HANDLE_W-1:0]      m_out_handle,
    output logic [TYPE_W-1:0]        m_out_type,
    output logic signed [PRIO_W-1:0] m_out_priority,
    output logic [OUT_CNT_W-1:0]     m_count
);

    // Commands from the sequencer to the cell row.
    ctrl_cmd_t ctrl;

    spq_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .in_cmd       (s_cmd),
        .in_handle    (s_item_handle),
        .in_type      (s_item_type),
        .in_priority  (s_priority_req),
        .res_status   (m_status),
        .res_handle   (m_out_handle),
        .res_type     (m_out_type),
        .res_priority (m_out_priority),
        .res_count    (m_count)
    );

endmodule

[rtl/spq_datapath.sv]
// ============================================================================
// spq_datapath
// Row of sorted storage cells with per-cell compare logic, the held count and
// the result register. Each cell compares its own entry in parallel; the
// update shifts the row up (insert) or down (remove) in one step.
// ============================================================================
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ctrl_cmd_t                ctrl,
    input  logic                     in_cmd,
    input  logic [HANDLE_W-1:0]      in_handle,
    input  logic [TYPE_W-1:0]        in_type,
    input  logic signed [PRIO_W-1:0] in_priority,
    output logic [STATUS_W-1:0]      res_status,
    output logic [HANDLE_W-1:0]      res_handle,
    output logic [TYPE_W-1:0]        res_type,
    output logic signed [PRIO_W-1:0] res_priority,
    output logic [OUT_CNT_W-1:0]     res_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Captured item.
    logic                     cmd_reg;
    logic [HANDLE_W-1:0]      handle_reg;
    logic [TYPE_W-1:0]        type_reg;
    logic signed [PRIO_W-1:0] prio_reg;

    // Storage cells, index 0 is the head.
    logic [HANDLE_W-1:0]      cell_h_reg [CAPACITY];
    logic [TYPE_W-1:0]        cell_t_reg [CAPACITY];
    logic signed [PRIO_W-1:0] cell_p_reg [CAPACITY];
    logic [HANDLE_W-1:0]      cell_h_next [CAPACITY];
    logic [TYPE_W-1:0]        cell_t_next [CAPACITY];
    logic signed [PRIO_W-1:0] cell_p_next [CAPACITY];

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // Per-cell flags, registered between the compare and update cycles.
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] shift_reg;
    logic [CAPACITY-1:0] match_next;
    logic [CAPACITY-1:0] shift_next;

    // Result register payload.
    logic [STATUS_W-1:0]      status_reg;
    logic [HANDLE_W-1:0]      oh_reg;
    logic [TYPE_W-1:0]        ot_reg;
    logic signed [PRIO_W-1:0] op_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [HANDLE_W-1:0]      oh_next;
    logic [TYPE_W-1:0]        ot_next;
    logic signed [PRIO_W-1:0] op_next;

    logic is_full;
    logic is_empty;
    logic do_insert;
    logic do_remove;

    genvar gi;

    // A cell takes part in the shift when it is unused or holds a strictly
    // larger priority, so equal priorities keep their arrival order.
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            always_comb begin
                match_next[gi] = (CNT_W'(gi) < count_reg) && (cell_h_reg[gi] == handle_reg);
                shift_next[gi] = (CNT_W'(gi) >= count_reg) || (prio_reg < cell_p_reg[gi]);
            end

            always_comb begin
                cell_h_next[gi] = cell_h_reg[gi];
                cell_t_next[gi] = cell_t_reg[gi];
                cell_p_next[gi] = cell_p_reg[gi];
                if (do_insert && shift_reg[gi]) begin
                    cell_h_next[gi] = handle_reg;
                    cell_t_next[gi] = type_reg;
                    cell_p_next[gi] = prio_reg;
                    if (gi > 0) begin
                        if (shift_reg[(gi > 0) ? gi - 1 : 0]) begin
                            cell_h_next[gi] = cell_h_reg[(gi > 0) ? gi - 1 : 0];
                            cell_t_next[gi] = cell_t_reg[(gi > 0) ? gi - 1 : 0];
                            cell_p_next[gi] = cell_p_reg[(gi > 0) ? gi - 1 : 0];
                        end
                    end
                end else if (do_remove && (gi < CAPACITY - 1)) begin
                    cell_h_next[gi] = cell_h_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                    cell_t_next[gi] = cell_t_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                    cell_p_next[gi] = cell_p_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                end
            end
        end
    endgenerate

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Operation outcome, in the order the checks take precedence.
    always_comb begin
        status_next = ST_OK;
        oh_next     = '0;
        ot_next     = '0;
        op_next     = '0;
        count_next  = count_reg;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        if (cmd_reg == CMD_INSERT) begin
            priority if (handle_reg == '0) begin
                status_next = ST_NULL;
            end else if (is_full) begin
                status_next = ST_FULL;
            end else if (|match_reg) begin
                status_next = ST_DUP;
            end else begin
                do_insert  = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                status_next = ST_EMPTY;
            end else begin
                do_remove  = 1'b1;
                oh_next    = cell_h_reg[0];
                ot_next    = cell_t_reg[0];
                op_next    = cell_p_reg[0];
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.commit) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg    <= in_cmd;
            handle_reg <= in_handle;
            type_reg   <= in_type;
            prio_reg   <= in_priority;
        end
        if (ctrl.compare) begin
            match_reg <= match_next;
            shift_reg <= shift_next;
        end
        if (ctrl.commit) begin
            cell_h_reg <= cell_h_next;
            cell_t_reg <= cell_t_next;
            cell_p_reg <= cell_p_next;
            status_reg <= status_next;
            oh_reg     <= oh_next;
            ot_reg     <= ot_next;
            op_reg     <= op_next;
        end
    end

    assign res_status   = status_reg;
    assign res_handle   = oh_reg;
    assign res_type     = ot_reg;
    assign res_priority = op_reg;
    assign res_count    = OUT_CNT_W'(count_reg);

`ifndef SYNTHESIS
    // The held count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    // A committed insert that succeeds raises the count by one.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.commit && do_insert) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not raise the count");

    // The shift flags form a thermometer: once set, every higher cell is set.
    a_shift_thermo: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> ((shift_reg & ~(shift_reg << 1)) == '0
                         || $onehot(shift_reg & ~(shift_reg << 1))))
        else $error("shift flags not contiguous");
`endif

endmodule

[rtl/spq_controller.sv]
// ============================================================================
// spq_controller
// Sequencer for the priority queue: accepts one item, steps it through the
// compare and update cycles, and owns the result valid flag.
// ============================================================================
module spq_controller
    import spq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrl_cmd_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctrl         = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
                if (s_valid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ctrl.compare = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    ctrl.commit  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // A commit never overwrites a result that has not been transferred.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    // An accepted item moves to the compare cycle.
    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_CMP))
        else $error("accepted item did not enter compare");

    // A commit always presents a result in the next cycle.
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> m_valid_reg)
        else $error("commit without result");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench for the stable priority queue unit. A short table of
// directed commands covers the empty queue, null and duplicate handles, the
// full queue, the priority extremes and ties. Long random sequences follow.
// Every result is checked against a shadow copy of the sorted queue that the
// testbench keeps itself, or against a result typed into the directed table.
// ============================================================================
module tb_top;
    import spq_pkg::*;

    localparam int QCAP         = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1450;
    // No transfer on either channel for this many cycles means the block hung.
    // The longest legal quiet stretch is the long receiver hold, HOLD_CYCLES.
    localparam int HANG_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 80;

    // One result as it appears on the m_ channel.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [HANDLE_W-1:0]      handle;
        logic [TYPE_W-1:0]        otype;
        logic signed [PRIO_W-1:0] prio;
        logic [OUT_CNT_W-1:0]     count;
    } pq_result_t;

    // One command for the s_ channel. When fixed is set, the expected result
    // is the one typed into the table and not the one the shadow queue gives.
    typedef struct {
        logic                     cmd;
        logic [HANDLE_W-1:0]      handle;
        logic [TYPE_W-1:0]        itype;
        logic signed [PRIO_W-1:0] prio;
        bit                       fixed;
        pq_result_t               want;
    } pq_command_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic                     s_cmd          = CMD_INSERT;
    logic [HANDLE_W-1:0]      s_item_handle  = '0;
    logic [TYPE_W-1:0]        s_item_type    = '0;
    logic signed [PRIO_W-1:0] s_priority_req = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [STATUS_W-1:0]      m_status;
    logic [HANDLE_W-1:0]      m_out_handle;
    logic [TYPE_W-1:0]        m_out_type;
    logic signed [PRIO_W-1:0] m_out_priority;
    logic [OUT_CNT_W-1:0]     m_count;

    // Shadow copy of the queue contents, head at index 0, sorted by priority.
    logic [HANDLE_W-1:0]      shadow_handle [QCAP];
    logic [TYPE_W-1:0]        shadow_itype  [QCAP];
    logic signed [PRIO_W-1:0] shadow_prio   [QCAP];
    int                       shadow_count = 0;

    pq_result_t  pending_results[$];
    pq_command_t directed_rows[$];

    int mismatches  = 0;
    int idle_cycles = 0;
    bit send_burst  = 1'b0;
    bit recv_burst  = 1'b0;

    stable_priority_queue_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_item_handle  (s_item_handle),
        .s_item_type    (s_item_type),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_handle   (m_out_handle),
        .m_out_type     (m_out_type),
        .m_out_priority (m_out_priority),
        .m_count        (m_count)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Applies one command to the shadow queue and returns the result the block
    // must report for it. The checks take precedence in a fixed order: a null
    // handle is rejected first, then a full queue, and only then a duplicate
    // handle found anywhere in the queue. Rejections leave the queue untouched.
    function automatic pq_result_t apply_to_shadow_queue(
        logic cmd, logic [HANDLE_W-1:0] handle, logic [TYPE_W-1:0] itype,
        logic signed [PRIO_W-1:0] prio);
        pq_result_t res;
        int         slot;
        bit         seen;

        res  = '0;
        slot = shadow_count;
        seen = 1'b0;
        if (cmd == CMD_INSERT) begin
            for (int i = 0; i < shadow_count; i++) begin
                if (shadow_handle[i] == handle) begin
                    seen = 1'b1;
                end
            end
            if (handle == '0) begin
                res.status = ST_NULL;
            end else if (shadow_count >= QCAP) begin
                res.status = ST_FULL;
            end else if (seen) begin
                res.status = ST_DUP;
            end else begin
                // The new entry goes ahead of the first strictly larger
                // priority, so it lands behind every equal one already held.
                for (int i = shadow_count - 1; i >= 0; i--) begin
                    if (prio < shadow_prio[i]) begin
                        slot = i;
                    end
                end
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_handle[i] = shadow_handle[i-1];
                    shadow_itype[i]  = shadow_itype[i-1];
                    shadow_prio[i]   = shadow_prio[i-1];
                end
                shadow_handle[slot] = handle;
                shadow_itype[slot]  = itype;
                shadow_prio[slot]   = prio;
                shadow_count++;
                res.status = ST_OK;
            end
        end else if (shadow_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.status = ST_OK;
            res.handle = shadow_handle[0];
            res.otype  = shadow_itype[0];
            res.prio   = shadow_prio[0];
            for (int i = 1; i < shadow_count; i++) begin
                shadow_handle[i-1] = shadow_handle[i];
                shadow_itype[i-1]  = shadow_itype[i];
                shadow_prio[i-1]   = shadow_prio[i];
            end
            shadow_count--;
        end
        res.count = OUT_CNT_W'(shadow_count);
        return res;
    endfunction

    // Appends a row to the directed table. Typed rows only ever carry results
    // whose entry fields are zero, so status and count are all they need.
    function automatic void add_row(logic cmd, logic [HANDLE_W-1:0] handle,
        logic [TYPE_W-1:0] itype, logic signed [PRIO_W-1:0] prio, bit fixed,
        logic [STATUS_W-1:0] status, logic [OUT_CNT_W-1:0] count);
        pq_command_t row;

        row.cmd         = cmd;
        row.handle      = handle;
        row.itype       = itype;
        row.prio        = prio;
        row.fixed       = fixed;
        row.want        = '0;
        row.want.status = status;
        row.want.count  = count;
        directed_rows.push_back(row);
    endfunction

    // Offers one command after a random gap and waits for its transfer. Valid
    // is only lowered when there is a gap, so back-to-back commands keep it
    // high without a second assignment in the same time step.
    task automatic send_command(input pq_command_t row);
        int         gap;
        pq_result_t predicted;

        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= row.cmd;
        s_item_handle  <= row.handle;
        s_item_type    <= row.itype;
        s_priority_req <= row.prio;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // The transfer happened at this edge; the shadow queue always moves
        // on, even when the table supplies the expected result.
        predicted = apply_to_shadow_queue(row.cmd, row.handle, row.itype, row.prio);
        pending_results.push_back(row.fixed ? row.want : predicted);
    endtask

    task automatic check_field(string field_name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field_name, want, got);
            mismatches++;
        end
    endtask

    // Result checker. Inputs are driven with nonblocking assignments, so the
    // values seen here at the edge are the ones the block sampled.
    always @(posedge aclk) begin : result_check
        pq_result_t want;

        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with no expected result, actual status %h",
                         $time, m_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("out_handle", want.handle, m_out_handle);
                check_field("out_type", 32'(want.otype), 32'(m_out_type));
                check_field("out_priority", 32'(want.prio), 32'(m_out_priority));
                check_field("count", 32'(want.count), 32'(m_count));
            end
        end
    end

    // Hang detector: counts cycles in which neither channel completes a
    // transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("FAIL stable_priority_queue_unit");
            $finish;
        end
    end

    // Result receiver. It stalls for a random gap before each result, except
    // in stretches where it takes results as fast as they come. Twice it holds
    // ready low for a long stretch while the sender keeps offering commands,
    // so the result register stays occupied and the block has to stall its
    // input side.
    initial begin : receiver
        int gap;
        int taken;

        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == 250 || taken == 900) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = recv_burst ? 0 : $urandom_range(0, 4);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
            if (taken % 120 == 0) begin
                recv_burst = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin : stimulus
        pq_command_t row;
        int          sent;
        int          seg_len;
        int          insert_pct;
        int          pick;

        // Directed table. Rows with an obvious result carry it typed in; the
        // rest are checked against the shadow queue.
        // Remove from the empty queue after reset.
        add_row(CMD_REMOVE, '0, '0, '0, 1'b1, ST_EMPTY, 5'd0);
        // Null handle is rejected.
        add_row(CMD_INSERT, '0, 16'h1234, 16'sd5, 1'b1, ST_NULL, 5'd0);
        // Largest handle, type and priority, then the smallest priority.
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'sh7FFF, 1'b1, ST_OK, 5'd1);
        add_row(CMD_INSERT, 32'h0000_0001, 16'h0000, 16'sh8000, 1'b1, ST_OK, 5'd2);
        // Same handle again, with a different type and priority.
        add_row(CMD_INSERT, 32'h0000_0001, 16'h00AA, 16'sd0, 1'b1, ST_DUP, 5'd2);
        // A tie at the lowest priority must queue behind the earlier entry.
        add_row(CMD_INSERT, 32'h8000_0000, 16'h5555, 16'sh8000, 1'b0, ST_OK, 5'd0);
        add_row(CMD_REMOVE, 32'hA5A5_A5A5, 16'h5A5A, 16'sh1234, 1'b0, ST_OK, 5'd0);
        // Fill to capacity with many equal priorities among small values.
        for (int i = 0; i < QCAP - 2; i++) begin
            add_row(CMD_INSERT, 32'h100 + i, 16'(i * 16'h1111), 16'(i % 3 - 1),
                    1'b0, ST_OK, 5'd0);
        end
        // On a full queue the full check wins over the duplicate check, and
        // the null check wins over both.
        add_row(CMD_INSERT, 32'h0000_0200, 16'h0001, 16'sd7, 1'b1, ST_FULL, 5'(QCAP));
        add_row(CMD_INSERT, '0, 16'h0002, 16'sd7, 1'b1, ST_NULL, 5'(QCAP));
        add_row(CMD_INSERT, 32'h8000_0000, 16'h0003, 16'sd7, 1'b1, ST_FULL, 5'(QCAP));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_command(directed_rows[i]);
        end

        // Random part, in segments with different insert-to-remove mixes so
        // the held count sweeps between empty and full. Handles come partly
        // from a small pool and partly from the entries held right now, which
        // makes duplicates common; priorities cluster around zero for ties.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(30, 80);
            case ($urandom_range(0, 4))
                0:       insert_pct = 90;
                1:       insert_pct = 65;
                2:       insert_pct = 50;
                3:       insert_pct = 35;
                default: insert_pct = 10;
            endcase
            send_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                row.cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    row.handle = '0;
                end else if (pick < 25 && shadow_count > 0) begin
                    row.handle = shadow_handle[$urandom_range(0, shadow_count - 1)];
                end else if (pick < 55) begin
                    row.handle = 32'($urandom_range(1, 48));
                end else begin
                    row.handle = $urandom();
                end
                row.itype = 16'($urandom());
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    row.prio = 16'(int'($urandom_range(0, 8)) - 4);
                end else if (pick < 55) begin
                    row.prio = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
                end else begin
                    row.prio = 16'($urandom());
                end
                row.fixed = 1'b0;
                row.want  = '0;
                send_command(row);
                sent++;
            end
        end
        s_valid <= 1'b0;

        // Drain the remaining results, then give a stray extra result time to show
        // up.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("PASS stable_priority_queue_unit");
        end else begin
            $display("FAIL stable_priority_queue_unit");
        end
        $finish;
    end

endmodule
